// File: hdl/integer_to_ascii_radix_macros.svh
// Assertion helpers used by the conversion datapath.
`ifndef INTEGER_TO_ASCII_RADIX_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ITAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen out of reset.
`define ITAR_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: hdl/itar_pkg.sv
package itar_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int RADIX_W        = 6;
  localparam int RDX_W          = 5;
  localparam int DIG_W          = 4;
  localparam int CHAR_W         = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN      = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX      = RADIX_W'(16);
  localparam logic [RDX_W-1:0]   RADIX_FALLBACK = RDX_W'(10);
  localparam logic [CHAR_W-1:0]  MINUS_CHAR     = 8'h2D;

  localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  typedef struct packed {
    logic load;
    logic emit_sign;
    logic div_step;
    logic push;
    logic pop_read;
    logic emit_digit;
  } itar_cmd_t;

  typedef struct packed {
    logic neg;
    logic div_last;
    logic quot_zero;
    logic stack_empty;
    logic out_free;
  } itar_sts_t;

endpackage

// File: hdl/itar_ctrl.sv
module itar_ctrl import itar_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  itar_sts_t sts,
  output itar_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIGN,
    ST_DIV,
    ST_PUSH,
    ST_READ,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (!sts.neg) begin
          state_nxt = ST_DIV;
        end else if (sts.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = sts.quot_zero ? ST_READ : ST_DIV;
      end
      ST_READ: begin
        cmd.pop_read = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          state_nxt      = sts.stack_empty ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/itar_dp.sv
`include "integer_to_ascii_radix_macros.svh"

module itar_dp import itar_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [VALUE_BITS-1:0] in_number_in,
  input  logic                  in_signed_mode,
  input  logic [RADIX_W-1:0]    in_radix,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAR_W-1:0]     out_char_out,
  output logic                  out_last_char,
  input  itar_cmd_t             cmd,
  output itar_sts_t             sts
);

  localparam int AW = $clog2(VALUE_BITS);
  localparam int CW = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] val_r;
  logic [DIG_W-1:0]      rem_r;
  logic [RDX_W-1:0]      rdx_r;
  logic [AW-1:0]         bitcnt_r;
  logic [CW-1:0]         cnt_r;
  logic                  neg_r;
  logic [DIG_W-1:0]      rd_dig_r;
  logic                  out_valid_r;
  logic [CHAR_W-1:0]     char_r;
  logic                  last_r;

  logic [DIG_W-1:0]      stack_mem [VALUE_BITS];

  logic                  is_neg;
  logic [VALUE_BITS-1:0] mag;
  logic                  radix_ok;
  logic [RDX_W-1:0]      rem_sh;
  logic                  q_bit;
  logic [RDX_W-1:0]      diff;
  logic [DIG_W-1:0]      rem_nxt;
  logic [CW-1:0]         cnt_dec;

  assign is_neg   = in_signed_mode && in_number_in[VALUE_BITS-1];
  assign mag      = is_neg ? (~in_number_in + VALUE_BITS'(1)) : in_number_in;
  assign radix_ok = (in_radix inside {[RADIX_MIN:RADIX_MAX]});

  assign rem_sh  = {rem_r, val_r[VALUE_BITS-1]};
  assign q_bit   = (rem_sh >= rdx_r);
  assign diff    = rem_sh - rdx_r;
  assign rem_nxt = q_bit ? diff[DIG_W-1:0] : rem_sh[DIG_W-1:0];
  assign cnt_dec = cnt_r - CW'(1);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        cnt_r <= '0;
      end else if (cmd.push) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (cmd.pop_read) begin
        cnt_r <= cnt_dec;
      end
      if (cmd.emit_sign || cmd.emit_digit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // divider and word registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r    <= mag;
      neg_r    <= is_neg;
      rdx_r    <= radix_ok ? in_radix[RDX_W-1:0] : RADIX_FALLBACK;
      rem_r    <= '0;
      bitcnt_r <= AW'(VALUE_BITS - 1);
    end else if (cmd.div_step) begin
      val_r    <= {val_r[VALUE_BITS-2:0], q_bit};
      rem_r    <= rem_nxt;
      bitcnt_r <= bitcnt_r - AW'(1);
    end else if (cmd.push) begin
      rem_r    <= '0;
      bitcnt_r <= AW'(VALUE_BITS - 1);
    end
    if (cmd.emit_sign) begin
      char_r <= MINUS_CHAR;
      last_r <= 1'b0;
    end else if (cmd.emit_digit) begin
      char_r <= DIGIT_CHARS[rd_dig_r];
      last_r <= (cnt_r == '0);
    end
  end

  // digit stack
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[cnt_r[AW-1:0]] <= rem_r;
    end
    if (cmd.pop_read) begin
      rd_dig_r <= stack_mem[cnt_dec[AW-1:0]];
    end
  end

  assign sts.neg         = neg_r;
  assign sts.div_last    = (bitcnt_r == '0);
  assign sts.quot_zero   = (val_r == '0);
  assign sts.stack_empty = (cnt_r == '0);
  assign sts.out_free    = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_char_out  = char_r;
  assign out_last_char = last_r;

  `ITAR_NEVER(a_push_full, cmd.push && (cnt_r == CW'(VALUE_BITS)), "digit stack overflow")
  `ITAR_NEVER(a_pop_empty, cmd.pop_read && (cnt_r == '0), "digit stack underflow")
  `ITAR_NEVER(a_out_clobber, (cmd.emit_sign || cmd.emit_digit) && out_valid_r && out_stall, "held word overwritten")
  `ITAR_ASSERT(a_sign_neg, cmd.emit_sign |-> neg_r, "minus sign on non-negative value")

endmodule

// File: hdl/integer_to_ascii_radix.sv
// Converts a VALUE_BITS-bit value to its ASCII digits in radix 2 to 16 (any other radix
// acts as 10), most significant first, one word per character, last_char on the final
// one; in signed mode a negative value starts with '-'. One value is converted at a time:
// a bit-serial restoring divider yields one quotient bit per cycle, and each remainder is
// pushed onto the digit stack; the digits are then popped from the stack and presented one
// at a time, each waiting while the receiver stalls the held word. The sign step is taken
// for every value, and a '-' is emitted there before any division starts.
module integer_to_ascii_radix import itar_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] in_number_in,
  input  logic                  in_signed_mode,
  input  logic [RADIX_W-1:0]    in_radix,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAR_W-1:0]     out_char_out,
  output logic                  out_last_char
);

  itar_cmd_t cmd;
  itar_sts_t sts;

  itar_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  itar_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_number_in   (in_number_in),
    .in_signed_mode (in_signed_mode),
    .in_radix       (in_radix),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_out   (out_char_out),
    .out_last_char  (out_last_char),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

// File: dv/integer_to_ascii_radix_tb.sv
module integer_to_ascii_radix_tb import itar_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VB          = VALUE_BITS_DEF;
  localparam int RANDOM_VALS = 160;
  localparam int HOLD_CYCLES = 3000;
  localparam int DRAIN_WAIT  = 200;
  localparam int DIRECTED_N  = 22;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_word_t;

  typedef struct {
    logic [VB-1:0]      value;
    logic               sgn;
    logic [RADIX_W-1:0] rdx;
    string              text;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [VB-1:0]        in_number_in;
  logic                 in_signed_mode;
  logic [RADIX_W-1:0]   in_radix;
  logic                 out_valid;
  logic                 out_stall;
  logic [CHAR_W-1:0]    out_char_out;
  logic                 out_last_char;

  char_word_t expected_chars [$];
  char_word_t got_word;
  int         error_count;
  int         chars_seen;
  int         values_sent;
  int         negatives_sent;
  int         fallback_sent;
  bit         long_hold_done;

  stim_row_t stim_rows [DIRECTED_N] = '{
    '{32'h0000_0000, 1'b0, 6'd10, "0"},
    '{32'h0000_0000, 1'b1, 6'd2,  "0"},
    '{32'hFFFF_FFFF, 1'b0, 6'd16, "ffffffff"},
    '{32'hFFFF_FFFF, 1'b0, 6'd2,  ""},
    '{32'hFFFF_FFFF, 1'b0, 6'd10, "4294967295"},
    '{32'hFFFF_FFFF, 1'b1, 6'd10, "-1"},
    '{32'hFFFF_FFFF, 1'b1, 6'd2,  "-1"},
    '{32'h8000_0000, 1'b1, 6'd10, "-2147483648"},
    '{32'h8000_0000, 1'b1, 6'd2,  ""},
    '{32'h8000_0000, 1'b1, 6'd16, "-80000000"},
    '{32'h8000_0000, 1'b0, 6'd10, "2147483648"},
    '{32'h7FFF_FFFF, 1'b1, 6'd10, "2147483647"},
    '{32'd12345,     1'b0, 6'd0,  "12345"},
    '{32'd12345,     1'b1, 6'd1,  "12345"},
    '{32'd12345,     1'b0, 6'd17, "12345"},
    '{32'd12345,     1'b1, 6'd63, "12345"},
    '{32'd255,       1'b0, 6'd8,  "377"},
    '{32'hDEAD_BEEF, 1'b0, 6'd16, "deadbeef"},
    '{32'hDEAD_BEEF, 1'b1, 6'd16, ""},
    '{32'hFEDC_BA98, 1'b0, 6'd3,  ""},
    '{32'd5,         1'b0, 6'd5,  ""},
    '{32'hFFFF_FF85, 1'b1, 6'd7,  ""}
  };

  integer_to_ascii_radix u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_number_in  (in_number_in),
    .in_signed_mode(in_signed_mode),
    .in_radix      (in_radix),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_out  (out_char_out),
    .out_last_char (out_last_char)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("FAIL integer_to_ascii_radix");
    $finish;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic void predict_digits(input logic [VB-1:0] value, input logic sgn,
                                         input logic [RADIX_W-1:0] rdx);
    logic [VB-1:0]     mag;
    logic [VB-1:0]     base;
    logic [VB-1:0]     d;
    logic [CHAR_W-1:0] digs [$];
    logic [CHAR_W-1:0] ch;
    mag  = value;
    base = (rdx < RADIX_MIN || rdx > RADIX_MAX) ? VB'(RADIX_FALLBACK) : VB'(rdx);
    if (sgn && value[VB-1]) begin
      expected_chars.push_back('{ch: MINUS_CHAR, last: 1'b0});
      mag = -value;
    end
    do begin
      d = mag % base;
      digs.push_front((d < 10) ? CHAR_W'(8'h30 + d) : CHAR_W'(8'h61 + d - 10));
      mag = mag / base;
    end while (mag != 0);
    while (digs.size() != 0) begin
      ch = digs.pop_front();
      expected_chars.push_back('{ch: ch, last: (digs.size() == 0)});
    end
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      expected_chars.push_back('{ch: CHAR_W'(s[i]), last: (i == s.len() - 1)});
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [VB-1:0] pick_value();
    int r;
    r = $urandom_range(0, 7);
    case (r)
      0, 1: return VB'($urandom_range(0, 300));
      2: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return '1;
          2: return {1'b1, {(VB-1){1'b0}}};
          3: return {1'b0, {(VB-1){1'b1}}};
          default: return VB'(1);
        endcase
      end
      3, 4: return VB'($urandom) >> $urandom_range(0, VB - 1);
      default: return VB'($urandom);
    endcase
  endfunction

  task automatic offer_value(input logic [VB-1:0] value, input logic sgn,
                             input logic [RADIX_W-1:0] rdx, input string text);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_number_in   = value;
    in_signed_mode = sgn;
    in_radix       = rdx;
    in_valid       = 1'b1;
    do @(posedge clk); while (in_stall);
    values_sent++;
    if (sgn && value[VB-1]) negatives_sent++;
    if (rdx < RADIX_MIN || rdx > RADIX_MAX) fallback_sent++;
    if (text.len() != 0) push_text(text);
    else predict_digits(value, sgn, rdx);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      chars_seen++;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %h last %b", out_char_out, out_last_char));
      end else begin
        got_word = expected_chars.pop_front();
        if (out_char_out !== got_word.ch)
          report_mismatch($sformatf("char %h, want %h", out_char_out, got_word.ch));
        if (out_last_char !== got_word.last)
          report_mismatch($sformatf("last_char %b, want %b on %h", out_last_char,
                                    got_word.last, got_word.ch));
      end
    end
  end

  initial begin
    int r;
    int stall_left;
    int quiet_left;
    stall_left = 0;
    quiet_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && chars_seen >= 40) begin
        long_hold_done = 1'b1;
        out_stall      = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
      end else if (quiet_left > 0) begin
        quiet_left--;
        out_stall = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) quiet_left = $urandom_range(100, 400);
        else if (r < 9) stall_left = $urandom_range(10, 50);
        else if (r < 40) stall_left = $urandom_range(1, 3);
        out_stall = 1'b0;
      end
    end
  end

  initial begin
    logic [RADIX_W-1:0] rdx;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_number_in   = '0;
    in_signed_mode = 1'b0;
    in_radix       = '0;
    error_count    = 0;
    chars_seen     = 0;
    values_sent    = 0;
    negatives_sent = 0;
    fallback_sent  = 0;
    long_hold_done = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (stim_rows[i])
      offer_value(stim_rows[i].value, stim_rows[i].sgn, stim_rows[i].rdx, stim_rows[i].text);

    for (int n = 0; n < RANDOM_VALS; n++) begin
      if ($urandom_range(0, 4) == 0) rdx = RADIX_W'($urandom_range(0, 63));
      else rdx = RADIX_W'($urandom_range(2, 16));
      offer_value(pick_value(), 1'($urandom_range(0, 1)), rdx, "");
    end
    in_valid = 1'b0;

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Converted %0d values (%0d negative, %0d with radix out of range),",
             values_sent, negatives_sent, fallback_sent);
    $display("checked %0d characters under random idling and one long receiver hold",
             chars_seen);
    if (error_count == 0) begin
      $display("PASS integer_to_ascii_radix");
    end else begin
      $display("FAIL integer_to_ascii_radix");
    end
    $finish;
  end

endmodule
